>>> rtl/assert_macros.svh
// Assertion macros shared by the look-at view matrix RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/lav_pkg.sv
// Package of the look-at view matrix block: types, constants and helper functions.
// No dependencies; the top module and the lav_ modules use it.
`timescale 1ns / 1ps
package lav_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam logic [4:0] SQ_TERMS = 5'd3;
    localparam logic [4:0] CROSS_TERMS = 5'd6;
    localparam logic [4:0] DOT_TERMS = 5'd9;
    localparam logic [4:0] DIV_STEPS = 5'd17;

    typedef logic signed [31:0] t_q16;

    typedef struct packed {
        t_q16 [2:0]        eye;
        t_q16 [2:0]        up;
        logic [2:0][32:0]  dir;
    } t_work;

    typedef struct packed {
        t_q16 [2:0] ax;
        t_q16 [2:0] ay;
        t_q16 [2:0] az;
        t_q16 [2:0] tr;
        logic       degen;
    } t_result;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_NLOAD,
        BK_NSHIFT,
        BK_NSQ,
        BK_NSQRT,
        BK_NDIV,
        BK_CROSS,
        BK_YRND,
        BK_DOT,
        BK_DONE
    } t_bk_state;

    function automatic logic [1:0] nxt1(input logic [1:0] i);
        case (i)
            2'd0: return 2'd1;
            2'd1: return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] nxt2(input logic [1:0] i);
        case (i)
            2'd0: return 2'd2;
            2'd1: return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic logic [1:0] dot_axis(input logic [3:0] c);
        case (c)
            4'd0, 4'd1, 4'd2: return 2'd0;
            4'd3, 4'd4, 4'd5: return 2'd1;
            default: return 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] dot_comp(input logic [3:0] c);
        case (c)
            4'd0, 4'd3, 4'd6: return 2'd0;
            4'd1, 4'd4, 4'd7: return 2'd1;
            default: return 2'd2;
        endcase
    endfunction

    function automatic logic signed [32:0] sext33(input t_q16 v);
        return {v[31], v};
    endfunction

    function automatic logic signed [63:0] round_q32(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? 64'(-v) : 64'(v);
        rnd = (mag + 64'd32768) >> 16;
        return v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

    function automatic t_q16 sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return $signed(v[31:0]);
    endfunction

endpackage

>>> rtl/lav_if.sv
// Valid/ready channel interfaces for the input points and the matrix row beats.
// No dependencies.
`timescale 1ns / 1ps
interface lav_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
        output ready
    );
endinterface

interface lav_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
    logic               degenerate;

    modport source (
        output valid, row_index, col0, col1, col2, col3, last_row, degenerate,
        input  ready
    );
    modport sink (
        input  valid, row_index, col0, col1, col2, col3, last_row, degenerate,
        output ready
    );
endinterface

>>> rtl/look_at_view_matrix.sv
// Left-handed look-at view matrix in signed Q16.16. Each input beat (eye, target, up)
// yields four row beats: rows 0 to 2 carry the x, y and z axis components with a zero
// last column, row 3 the negated eye dot products and 1.0, and degenerate marks a
// zero-length forward or side axis. The solver takes one item at a time, with its 33 by
// 33 bit shared multiplier, the one-bit-per-cycle normalizing shift, the 32-step square
// root and the 17-step divider, all used for both axes; meanwhile the front register and
// the queue keep taking input beats until the queue is full, and the row emitter sends the
// previous matrix at one row per cycle while the sink is ready.
// Depends on lav_pkg, lav_if and the lav_ modules.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module look_at_view_matrix #(
    parameter int unsigned QUEUE_DEPTH = lav_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_in_if.sink    i_in,
    lav_out_if.source o_out
);

    logic             f_valid;
    logic             f_ready;
    lav_pkg::t_work   f_work;
    logic             q_valid;
    logic             q_ready;
    lav_pkg::t_work   q_work;
    logic             res_valid;
    logic             res_ready;
    lav_pkg::t_result res;

    lav_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_work  (f_work),
        .i_ready (f_ready)
    );

    lav_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_data  (f_work),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_data  (q_work),
        .i_ready (q_ready)
    );

    lav_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_work  (q_work),
        .o_ready (q_ready),
        .o_valid (res_valid),
        .o_res   (res),
        .i_ready (res_ready)
    );

    lav_rows u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (res_ready),
        .o_out   (o_out)
    );

    `ASSERT_IMPLY(a_last_row, o_out.valid, o_out.last_row == (o_out.row_index == lav_pkg::ROW_LAST))
    `ASSERT_IMPLY(a_col3_zero, o_out.valid && (o_out.row_index != lav_pkg::ROW_LAST), o_out.col3 == '0)
    `ASSERT_NEXT(a_rows_run, o_out.valid && o_out.ready && (o_out.row_index != lav_pkg::ROW_LAST), o_out.valid)
    `ASSERT_NEXT(a_res_start, res_valid && res_ready, o_out.valid && (o_out.row_index == 2'd0))

endmodule

>>> rtl/lav_front.sv
// Front stage: registers an input beat and forms the view direction target - eye.
// Depends on lav_pkg and lav_in_if.
`timescale 1ns / 1ps
module lav_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lav_in_if.sink        i_in,
    output logic          o_valid,
    output lav_pkg::t_work o_work,
    input  logic          i_ready
);

    logic           r_valid;
    lav_pkg::t_work r_work;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_work     = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_work.eye[0] <= i_in.eye_x;
            r_work.eye[1] <= i_in.eye_y;
            r_work.eye[2] <= i_in.eye_z;
            r_work.up[0]  <= i_in.up_x;
            r_work.up[1]  <= i_in.up_y;
            r_work.up[2]  <= i_in.up_z;
            r_work.dir[0] <= {i_in.target_x[31], i_in.target_x} - {i_in.eye_x[31], i_in.eye_x};
            r_work.dir[1] <= {i_in.target_y[31], i_in.target_y} - {i_in.eye_y[31], i_in.eye_y};
            r_work.dir[2] <= {i_in.target_z[31], i_in.target_z} - {i_in.eye_z[31], i_in.eye_z};
        end
    end

endmodule

>>> rtl/lav_queue.sv
// Short queue that decouples the front stage from the matrix solver.
// Depends on lav_pkg.
`timescale 1ns / 1ps
module lav_queue #(
    parameter int unsigned DEPTH = lav_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lav_pkg::t_work i_data,
    output logic           o_ready,
    output logic           o_valid,
    output lav_pkg::t_work o_data,
    input  logic           i_ready
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]  r_count;
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    lav_pkg::t_work r_mem [DEPTH];
    logic           push;
    logic           pop;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/lav_back.sv
// Matrix solver: normalizes the axes with a shared multiplier, a bit-serial square
// root and a bit-serial divider, then forms the up axis and the translation row.
// Depends on lav_pkg.
`timescale 1ns / 1ps
module lav_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lav_pkg::t_work   i_work,
    output logic             o_ready,
    output logic             o_valid,
    output lav_pkg::t_result o_res,
    input  logic             i_ready
);

    lav_pkg::t_bk_state r_state, n_state;
    logic               r_pass;
    logic [4:0]         r_cnt;
    logic [1:0]         r_i;
    logic               r_pv;
    logic               r_psub;
    logic [1:0]         r_pdst;
    logic signed [65:0] r_prod;

    lav_pkg::t_q16      r_eye [3];
    lav_pkg::t_q16      r_up  [3];
    lav_pkg::t_q16      r_ax  [3];
    lav_pkg::t_q16      r_ay  [3];
    lav_pkg::t_q16      r_az  [3];
    logic signed [63:0] r_acc [3];
    logic [63:0]        r_m   [3];
    logic [2:0]         r_ng;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [31:0]        r_rem;
    logic [16:0]        r_num;
    logic [16:0]        r_q;
    logic               r_okz;
    logic               r_okx;

    logic               mul_go;
    logic               mul_sub;
    logic [1:0]         mul_dst;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               any_hi;
    logic               all_lo;
    logic               acc_zero;
    logic [1:0]         ci, cj, ck, dax, dcp;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    logic [63:0]        m_sel;
    logic               ng_sel;
    logic [31:0]        div_len;
    logic [47:0]        div_num;
    logic [32:0]        div_rem2;
    logic               div_ge;
    logic [16:0]        q_next;
    lav_pkg::t_q16      u_val;

    function automatic logic [29:0] m_sq(input logic [1:0] k);
        case (k)
            2'd0: return r_m[0][29:0];
            2'd1: return r_m[1][29:0];
            default: return r_m[2][29:0];
        endcase
    endfunction

    assign any_hi   = (|r_m[0][63:30]) | (|r_m[1][63:30]) | (|r_m[2][63:30]);
    assign all_lo   = ~((|r_m[0][63:29]) | (|r_m[1][63:29]) | (|r_m[2][63:29]));
    assign acc_zero = (r_acc[0] == '0) && (r_acc[1] == '0) && (r_acc[2] == '0);
    assign sq_sum   = r_root + r_bit;
    assign sq_ge    = $unsigned(r_acc[0]) >= sq_sum;
    assign m_sel    = (r_i == 2'd0) ? r_m[0] : ((r_i == 2'd1) ? r_m[1] : r_m[2]);
    assign ng_sel   = (r_i == 2'd0) ? r_ng[0] : ((r_i == 2'd1) ? r_ng[1] : r_ng[2]);
    assign div_len  = r_root[31:0];
    assign div_num  = {m_sel[31:0], 16'b0} + {17'b0, div_len[31:1]};
    assign div_rem2 = {r_rem, r_num[16]};
    assign div_ge   = div_rem2 >= {1'b0, div_len};
    assign q_next   = {r_q[15:0], div_ge};
    assign u_val    = ng_sel ? -$signed({15'b0, q_next}) : $signed({15'b0, q_next});

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        mul_go  = 1'b0;
        mul_sub = 1'b0;
        mul_dst = 2'd0;
        mul_a   = '0;
        mul_b   = '0;
        ci      = r_cnt[2:1];
        cj      = lav_pkg::nxt1(r_cnt[2:1]);
        ck      = lav_pkg::nxt2(r_cnt[2:1]);
        dax     = lav_pkg::dot_axis(r_cnt[3:0]);
        dcp     = lav_pkg::dot_comp(r_cnt[3:0]);
        case (r_state)
            lav_pkg::BK_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = lav_pkg::BK_NLOAD;
                end
            end
            lav_pkg::BK_NLOAD: begin
                n_state = acc_zero ? lav_pkg::BK_CROSS : lav_pkg::BK_NSHIFT;
            end
            lav_pkg::BK_NSHIFT: begin
                if (!any_hi && !all_lo) begin
                    n_state = lav_pkg::BK_NSQ;
                end
            end
            lav_pkg::BK_NSQ: begin
                if (r_cnt < lav_pkg::SQ_TERMS) begin
                    mul_go = 1'b1;
                    mul_a  = {3'b0, m_sq(r_cnt[1:0])};
                    mul_b  = {3'b0, m_sq(r_cnt[1:0])};
                end else begin
                    n_state = lav_pkg::BK_NSQRT;
                end
            end
            lav_pkg::BK_NSQRT: begin
                if (r_bit[0]) begin
                    n_state = lav_pkg::BK_NDIV;
                end
            end
            lav_pkg::BK_NDIV: begin
                if (r_cnt == lav_pkg::DIV_STEPS && r_i == 2'd2) begin
                    n_state = lav_pkg::BK_CROSS;
                end
            end
            lav_pkg::BK_CROSS: begin
                if (r_cnt < lav_pkg::CROSS_TERMS) begin
                    mul_go  = 1'b1;
                    mul_sub = r_cnt[0];
                    mul_dst = ci;
                    if (!r_pass) begin
                        mul_a = lav_pkg::sext33(r_cnt[0] ? r_up[ck] : r_up[cj]);
                        mul_b = lav_pkg::sext33(r_cnt[0] ? r_az[cj] : r_az[ck]);
                    end else begin
                        mul_a = lav_pkg::sext33(r_cnt[0] ? r_az[ck] : r_az[cj]);
                        mul_b = lav_pkg::sext33(r_cnt[0] ? r_ax[cj] : r_ax[ck]);
                    end
                end else begin
                    n_state = r_pass ? lav_pkg::BK_YRND : lav_pkg::BK_NLOAD;
                end
            end
            lav_pkg::BK_YRND: begin
                n_state = lav_pkg::BK_DOT;
            end
            lav_pkg::BK_DOT: begin
                if (r_cnt < lav_pkg::DOT_TERMS) begin
                    mul_go  = 1'b1;
                    mul_dst = dax;
                    mul_b   = lav_pkg::sext33(r_eye[dcp]);
                    case (dax)
                        2'd0: mul_a = lav_pkg::sext33(r_ax[dcp]);
                        2'd1: mul_a = lav_pkg::sext33(r_ay[dcp]);
                        default: mul_a = lav_pkg::sext33(r_az[dcp]);
                    endcase
                end else begin
                    n_state = lav_pkg::BK_DONE;
                end
            end
            lav_pkg::BK_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = lav_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lav_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_res.ax[k] = r_ax[k];
            o_res.ay[k] = r_ay[k];
            o_res.az[k] = r_az[k];
            o_res.tr[k] = lav_pkg::sat32(-lav_pkg::round_q32(r_acc[k]));
        end
        o_res.degen = !(r_okz && r_okx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lav_pkg::BK_IDLE;
            r_pass  <= 1'b0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= mul_go;
            case (r_state)
                lav_pkg::BK_IDLE: begin
                    r_pass <= 1'b0;
                    r_cnt  <= '0;
                end
                lav_pkg::BK_NSQ: begin
                    r_cnt <= (r_cnt == lav_pkg::SQ_TERMS) ? '0 : r_cnt + 1'b1;
                end
                lav_pkg::BK_NSQRT: begin
                    r_cnt <= '0;
                    r_i   <= '0;
                end
                lav_pkg::BK_NDIV: begin
                    if (r_cnt == lav_pkg::DIV_STEPS) begin
                        r_cnt <= '0;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                lav_pkg::BK_CROSS: begin
                    if (r_cnt == lav_pkg::CROSS_TERMS) begin
                        r_cnt  <= '0;
                        r_pass <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                lav_pkg::BK_DOT: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_psub <= mul_sub;
        r_pdst <= mul_dst;
        if (r_pv) begin
            r_acc[r_pdst] <= r_psub ? r_acc[r_pdst] - r_prod[63:0]
                                    : r_acc[r_pdst] + r_prod[63:0];
        end
        case (r_state)
            lav_pkg::BK_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_eye[k] <= i_work.eye[k];
                    r_up[k]  <= i_work.up[k];
                    r_acc[k] <= {{31{i_work.dir[k][32]}}, i_work.dir[k]};
                end
            end
            lav_pkg::BK_NLOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_ng[k] <= r_acc[k][63];
                    r_m[k]  <= r_acc[k][63] ? 64'(-r_acc[k]) : 64'(r_acc[k]);
                    if (acc_zero) begin
                        if (r_pass) begin
                            r_ax[k] <= '0;
                        end else begin
                            r_az[k] <= '0;
                        end
                    end
                end
                if (r_pass) begin
                    r_okx <= !acc_zero;
                end else begin
                    r_okz <= !acc_zero;
                end
            end
            lav_pkg::BK_NSHIFT: begin
                for (int k = 0; k < 3; k++) begin
                    if (any_hi) begin
                        r_m[k] <= r_m[k] >> 1;
                    end else if (all_lo) begin
                        r_m[k] <= r_m[k] << 1;
                    end
                end
            end
            lav_pkg::BK_NSQ: begin
                r_root <= '0;
                r_bit  <= lav_pkg::SQRT_BIT0;
                if (r_cnt == '0) begin
                    r_acc[0] <= '0;
                end
            end
            lav_pkg::BK_NSQRT: begin
                if (sq_ge) begin
                    r_acc[0] <= $signed($unsigned(r_acc[0]) - sq_sum);
                    r_root   <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            lav_pkg::BK_NDIV: begin
                if (r_cnt == '0) begin
                    r_rem <= {1'b0, div_num[47:17]};
                    r_num <= div_num[16:0];
                    r_q   <= '0;
                end else begin
                    r_rem <= div_ge ? 32'(div_rem2 - {1'b0, div_len}) : div_rem2[31:0];
                    r_num <= r_num << 1;
                    r_q   <= q_next;
                    if (r_cnt == lav_pkg::DIV_STEPS) begin
                        if (r_pass) begin
                            r_ax[r_i] <= u_val;
                        end else begin
                            r_az[r_i] <= u_val;
                        end
                    end
                end
            end
            lav_pkg::BK_CROSS, lav_pkg::BK_DOT: begin
                if (r_cnt == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= '0;
                    end
                end
            end
            lav_pkg::BK_YRND: begin
                for (int k = 0; k < 3; k++) begin
                    r_ay[k] <= 32'(lav_pkg::round_q32(r_acc[k]));
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/lav_rows.sv
// Row emitter: holds one solved matrix and sends it as four row beats.
// Depends on lav_pkg and lav_out_if.
`timescale 1ns / 1ps
module lav_rows (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lav_pkg::t_result i_res,
    output logic             o_ready,
    lav_out_if.source        o_out
);

    logic             r_busy;
    logic [1:0]       r_row;
    lav_pkg::t_result r_res;

    assign o_ready = !r_busy || (o_out.ready && r_row == lav_pkg::ROW_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (o_ready && i_valid) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (r_busy && o_out.ready) begin
            if (r_row == lav_pkg::ROW_LAST) begin
                r_busy <= 1'b0;
            end
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        o_out.valid      = r_busy;
        o_out.row_index  = r_row;
        o_out.last_row   = r_row == lav_pkg::ROW_LAST;
        o_out.degenerate = r_res.degen;
        case (r_row)
            2'd0, 2'd1, 2'd2: begin
                o_out.col0 = r_res.ax[r_row];
                o_out.col1 = r_res.ay[r_row];
                o_out.col2 = r_res.az[r_row];
                o_out.col3 = '0;
            end
            default: begin
                o_out.col0 = r_res.tr[0];
                o_out.col1 = r_res.tr[1];
                o_out.col2 = r_res.tr[2];
                o_out.col3 = lav_pkg::ONE_Q16;
            end
        endcase
    end

endmodule
